[rtl/rb2d_pkg.sv]
// shared types and constants for the 2d rigid body step
`default_nettype none
package rb2d_pkg;
  localparam int unsigned CfgW = 31;
  localparam logic [CfgW-1:0] MassRst = 31'd65536;
  localparam logic [CfgW-1:0] FricRst = 31'd13107200;
  localparam logic [CfgW-1:0] MaxXRst = 31'd13107200;
  localparam logic [CfgW-1:0] MaxYRst = 31'd65536000;

  typedef enum logic [1:0] {
    RegMass = 2'd0,
    RegFric = 2'd1,
    RegMaxX = 2'd2,
    RegMaxY = 2'd3
  } reg_idx_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone   = 4'd0,
    OpLoad   = 4'd1,
    OpDivX   = 4'd2,
    OpDivY   = 4'd3,
    OpAcc    = 4'd4,
    OpVel    = 4'd5,
    OpSqX    = 4'd6,
    OpSqY    = 4'd7,
    OpCmp    = 4'd8,
    OpSqrt   = 4'd9,
    OpFricX  = 4'd10,
    OpFricY  = 4'd11,
    OpFinish = 4'd12,
    OpPos    = 4'd13
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   last;   // final step of an iterative operation
  } dp_cmd_t;

  typedef struct packed {
    logic zero_vel; // velocity inside the friction circle
  } dp_sts_t;
endpackage
`default_nettype wire

[rtl/rb2d_ctrl.sv]
// sequencer for the step: issues datapath operations and counts iterations
`default_nettype none
module rb2d_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              out_ready_i,
  input  wire rb2d_pkg::dp_sts_t sts_i,
  output rb2d_pkg::dp_cmd_t      cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);
  typedef enum logic [14:0] {
    SIdle  = 15'b000000000000001,
    SLoad  = 15'b000000000000010,
    SDivX  = 15'b000000000000100,
    SDivY  = 15'b000000000001000,
    SAcc   = 15'b000000000010000,
    SVel   = 15'b000000000100000,
    SSqX   = 15'b000000001000000,
    SSqY   = 15'b000000010000000,
    SCmp   = 15'b000000100000000,
    SSqrt  = 15'b000001000000000,
    SFricX = 15'b000010000000000,
    SFricY = 15'b000100000000000,
    SFin   = 15'b001000000000000,
    SPos   = 15'b010000000000000,
    SDone  = 15'b100000000000000
  } state_e;

  localparam logic [5:0] DivLast  = 6'd47;
  localparam logic [5:0] SqrtLast = 6'd31;
  localparam logic [5:0] FricLast = 6'd63;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d = '0;
    cmd_o.op = rb2d_pkg::OpNone;
    cmd_o.last = 1'b0;
    done_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start_i) state_d = SLoad;
      end
      SLoad: begin
        cmd_o.op = rb2d_pkg::OpLoad;
        state_d = SDivX;
      end
      SDivX: begin
        cmd_o.op = rb2d_pkg::OpDivX;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DivLast) begin
          cmd_o.last = 1'b1;
          cnt_d = '0;
          state_d = SDivY;
        end
      end
      SDivY: begin
        cmd_o.op = rb2d_pkg::OpDivY;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DivLast) begin
          cmd_o.last = 1'b1;
          cnt_d = '0;
          state_d = SAcc;
        end
      end
      SAcc: begin
        cmd_o.op = rb2d_pkg::OpAcc;
        state_d = SVel;
      end
      SVel: begin
        cmd_o.op = rb2d_pkg::OpVel;
        state_d = SSqX;
      end
      SSqX: begin
        cmd_o.op = rb2d_pkg::OpSqX;
        state_d = SSqY;
      end
      SSqY: begin
        cmd_o.op = rb2d_pkg::OpSqY;
        state_d = SCmp;
      end
      SCmp: begin
        cmd_o.op = rb2d_pkg::OpCmp;
        state_d = sts_i.zero_vel ? SFin : SSqrt;
      end
      SSqrt: begin
        cmd_o.op = rb2d_pkg::OpSqrt;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == SqrtLast) begin
          cmd_o.last = 1'b1;
          cnt_d = '0;
          state_d = SFricX;
        end
      end
      SFricX: begin
        cmd_o.op = rb2d_pkg::OpFricX;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == FricLast) begin
          cmd_o.last = 1'b1;
          cnt_d = '0;
          state_d = SFricY;
        end
      end
      SFricY: begin
        cmd_o.op = rb2d_pkg::OpFricY;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == FricLast) begin
          cmd_o.last = 1'b1;
          cnt_d = '0;
          state_d = SFin;
        end
      end
      SFin: begin
        cmd_o.op = rb2d_pkg::OpFinish;
        state_d = SPos;
      end
      SPos: begin
        cmd_o.op = rb2d_pkg::OpPos;
        state_d = SDone;
      end
      SDone: begin
        // wait here while the previous word still sits in the output register
        done_o = out_ready_i;
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

[rtl/rb2d_dp.sv]
// datapath: shared restoring divider / square root and the axis arithmetic
`default_nettype none
module rb2d_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rb2d_pkg::dp_cmd_t cmd_i,
  output rb2d_pkg::dp_sts_t      sts_o,
  input  wire logic [30:0]       mass_i,
  input  wire logic [30:0]       fric_i,
  input  wire logic [30:0]       max_x_i,
  input  wire logic [30:0]       max_y_i,
  input  wire logic [31:0]       force_x_i,
  input  wire logic [31:0]       force_y_i,
  input  wire logic [31:0]       ex_x_i,
  input  wire logic [31:0]       ex_y_i,
  input  wire logic [15:0]       dt_i,
  input  wire logic [31:0]       pos_x_i,
  input  wire logic [31:0]       pos_y_i,
  output logic [31:0]            new_pos_x_o,
  output logic [31:0]            new_pos_y_o,
  output logic [31:0]            vel_x_o,
  output logic [31:0]            vel_y_o
);
  // kept velocity
  logic [31:0] velx_q, vely_q;
  logic [30:0] m_q;          // mass, zero taken as one lsb
  logic [30:0] f_q;          // friction per step
  logic [32:0] qx_q, qy_q;   // force over mass, clipped
  logic [31:0] ax_q, ay_q;
  logic [31:0] mx_q, my_q;   // velocity magnitudes
  logic sx_q, sy_q;
  logic [63:0] sq_q;
  logic [31:0] npx_q, npy_q;
  // shared iterative unit
  logic [63:0] num_q;        // shifting numerator / radicand
  logic [35:0] rem_q;
  logic [47:0] quo_q;
  logic [31:0] root_q;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'h7fffffff;
    if (v < -35'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // (|a| * dt) >> 16 with a's sign, 35-bit signed
  function automatic logic signed [34:0] tdt(input logic [31:0] a, input logic [15:0] dt);
    logic [47:0] p;
    logic [34:0] m;
    p = {16'd0, mag32(a)} * {32'd0, dt};
    m = {3'd0, p[47:16]};
    return a[31] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [34:0] sx35(input logic [31:0] v);
    return {{3{v[31]}}, v};
  endfunction

  // a quotient of 2^32 or more saturates the sum either way
  function automatic logic [32:0] clip33(input logic [47:0] q);
    return (q[47:33] != '0) ? 33'h1_0000_0000 : q[32:0];
  endfunction

  function automatic logic signed [34:0] accel(input logic [31:0] frc,
                                               input logic [32:0] q,
                                               input logic [31:0] ex);
    logic signed [34:0] sq;
    logic [34:0] qq;
    qq = {2'd0, q};
    sq = frc[31] ? -$signed(qq) : $signed(qq);
    return sq + sx35(ex);
  endfunction

  function automatic logic [31:0] clamp_axis(input logic s, input logic [31:0] m,
                                             input logic [30:0] lim);
    logic [31:0] c;
    c = (m > {1'b0, lim}) ? {1'b0, lim} : m;
    return s ? (~c + 32'd1) : c;
  endfunction

  logic [31:0] vxn, vyn;
  logic [46:0] fprod;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] div_d;
  logic [32:0] dv_sh, dv_rem;
  logic        dv_ge;
  logic [47:0] dv_quo;
  logic [35:0] sr_sh, sr_trial;
  logic        sr_ge;

  assign vxn = sat32(sx35(velx_q) + tdt(ax_q, dt_i));
  assign vyn = sat32(sx35(vely_q) + tdt(ay_q, dt_i));
  assign fprod = {16'd0, fric_i} * {31'd0, dt_i};

  // one shared multiplier for the squares, the friction square and the friction numerators
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      rb2d_pkg::OpSqX: begin
        mul_a = mx_q;
        mul_b = mx_q;
      end
      rb2d_pkg::OpSqY: begin
        mul_a = my_q;
        mul_b = my_q;
      end
      rb2d_pkg::OpCmp: begin
        mul_a = {1'b0, f_q};
        mul_b = {1'b0, f_q};
      end
      rb2d_pkg::OpSqrt: begin
        mul_a = mx_q;
        mul_b = {1'b0, f_q};
      end
      rb2d_pkg::OpFricX: begin
        mul_a = my_q;
        mul_b = {1'b0, f_q};
      end
      default: ;
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  assign sts_o.zero_vel = (sq_q <= mul_p);

  // restoring divide step, divisor is the mass or the root
  assign div_d = (cmd_i.op == rb2d_pkg::OpFricX || cmd_i.op == rb2d_pkg::OpFricY) ?
                 root_q : {1'b0, m_q};
  assign dv_sh = {rem_q[31:0], num_q[63]};
  assign dv_ge = (dv_sh >= {1'b0, div_d});
  assign dv_rem = dv_ge ? (dv_sh - {1'b0, div_d}) : dv_sh;
  assign dv_quo = {quo_q[46:0], dv_ge};

  // square-root digit step
  assign sr_sh = {rem_q[33:0], num_q[63:62]};
  assign sr_trial = {2'd0, root_q, 2'b01};
  assign sr_ge = (sr_sh >= sr_trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      velx_q <= '0;
      vely_q <= '0;
    end else if (cmd_i.op == rb2d_pkg::OpFinish) begin
      velx_q <= clamp_axis(sx_q, mx_q, max_x_i);
      vely_q <= clamp_axis(sy_q, my_q, max_y_i);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      rb2d_pkg::OpLoad: begin
        m_q <= (mass_i == '0) ? 31'd1 : mass_i;
        f_q <= fprod[46:16];
        num_q <= {mag32(force_x_i), 32'd0};
        rem_q <= '0;
        quo_q <= '0;
      end
      rb2d_pkg::OpDivX: begin
        if (cmd_i.last) begin
          qx_q <= clip33(dv_quo);
          num_q <= {mag32(force_y_i), 32'd0};
          rem_q <= '0;
          quo_q <= '0;
        end else begin
          num_q <= {num_q[62:0], 1'b0};
          rem_q <= {3'd0, dv_rem};
          quo_q <= dv_quo;
        end
      end
      rb2d_pkg::OpDivY: begin
        num_q <= {num_q[62:0], 1'b0};
        rem_q <= {3'd0, dv_rem};
        quo_q <= dv_quo;
        if (cmd_i.last) qy_q <= clip33(dv_quo);
      end
      rb2d_pkg::OpAcc: begin
        ax_q <= sat32(accel(force_x_i, qx_q, ex_x_i));
        ay_q <= sat32(accel(force_y_i, qy_q, ex_y_i));
      end
      rb2d_pkg::OpVel: begin
        mx_q <= mag32(vxn);
        my_q <= mag32(vyn);
        sx_q <= vxn[31];
        sy_q <= vyn[31];
      end
      rb2d_pkg::OpSqX: begin
        sq_q <= mul_p;
      end
      rb2d_pkg::OpSqY: begin
        sq_q <= sq_q + mul_p;
      end
      rb2d_pkg::OpCmp: begin
        num_q <= sq_q;
        rem_q <= '0;
        root_q <= '0;
        if (sts_o.zero_vel) begin
          mx_q <= '0;
          my_q <= '0;
        end
      end
      rb2d_pkg::OpSqrt: begin
        root_q <= {root_q[30:0], sr_ge};
        if (cmd_i.last) begin
          // seed the x friction divide with |vx| * f
          num_q <= mul_p;
          rem_q <= '0;
          quo_q <= '0;
        end else begin
          num_q <= {num_q[61:0], 2'b00};
          rem_q <= sr_ge ? (sr_sh - sr_trial) : sr_sh;
        end
      end
      rb2d_pkg::OpFricX: begin
        if (cmd_i.last) begin
          mx_q <= mx_q - dv_quo[31:0];
          num_q <= mul_p;
          rem_q <= '0;
          quo_q <= '0;
        end else begin
          num_q <= {num_q[62:0], 1'b0};
          rem_q <= {3'd0, dv_rem};
          quo_q <= dv_quo;
        end
      end
      rb2d_pkg::OpFricY: begin
        num_q <= {num_q[62:0], 1'b0};
        rem_q <= {3'd0, dv_rem};
        quo_q <= dv_quo;
        if (cmd_i.last) my_q <= my_q - dv_quo[31:0];
      end
      rb2d_pkg::OpPos: begin
        npx_q <= sat32(sx35(pos_x_i) + tdt(velx_q, dt_i));
        npy_q <= sat32(sx35(pos_y_i) + tdt(vely_q, dt_i));
      end
      default: ;
    endcase
  end

  assign vel_x_o = velx_q;
  assign vel_y_o = vely_q;
  assign new_pos_x_o = npx_q;
  assign new_pos_y_o = npy_q;
endmodule
`default_nettype wire

[rtl/rigid_body_2d_step.sv]
// top level of the 2d rigid body step with friction
// usage:
//   s_axis carries one tick: forces, extra acceleration, time step, position.
//   m_axis returns the new position and the kept velocity after the tick.
//   cfg_we_i / cfg_idx_i / cfg_data_i write mass, friction and speed limits
//   while the block is idle.
// timing:
//   one item at a time; the result is valid once the shared one-bit-per-cycle
//   divide and square-root unit has run two 48-step mass divides, a 32-step
//   square root and two 64-step friction divides, besides the load, accel,
//   velocity, two square, compare, finish, position and done steps. when the
//   velocity falls inside the friction circle the root and friction divides
//   are skipped. the input is ready again once the result is registered, so
//   the block takes no new item before the last one is through.
// reset:
//   velocity clears to zero and the registers take their defaults.
// stall:
//   a result is held in the output register until m_axis_tready; a finished
//   next item waits inside the block, with the input held off, until then.
`default_nettype none
module rigid_body_2d_step (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [30:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // force_x, force_y, extra_accel_x, extra_accel_y, time_step, pos_x, pos_y
  input  wire logic [207:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // new_pos_x, new_pos_y, vel_x, vel_y
  output logic [127:0]      m_axis_tdata
);
  logic [30:0] mass_q, fric_q, maxx_q, maxy_q;
  logic [207:0] in_q;
  logic busy, done, start, out_ready;
  logic ovalid_q;
  logic [127:0] odata_q;
  rb2d_pkg::dp_cmd_t cmd;
  rb2d_pkg::dp_sts_t sts;
  logic [31:0] npx, npy, vx, vy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= rb2d_pkg::MassRst;
      fric_q <= rb2d_pkg::FricRst;
      maxx_q <= rb2d_pkg::MaxXRst;
      maxy_q <= rb2d_pkg::MaxYRst;
    end else if (cfg_we_i) begin
      unique case (rb2d_pkg::reg_idx_e'(cfg_idx_i))
        rb2d_pkg::RegMass: mass_q <= cfg_data_i;
        rb2d_pkg::RegFric: fric_q <= cfg_data_i;
        rb2d_pkg::RegMaxX: maxx_q <= cfg_data_i;
        rb2d_pkg::RegMaxY: maxy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign start = s_axis_tvalid && s_axis_tready;
  assign out_ready = !ovalid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (start) in_q <= s_axis_tdata;
  end

  rb2d_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .out_ready_i(out_ready), .sts_i(sts),
    .cmd_o(cmd), .busy_o(busy), .done_o(done)
  );

  rb2d_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .mass_i(mass_q), .fric_i(fric_q), .max_x_i(maxx_q), .max_y_i(maxy_q),
    .force_x_i(in_q[31:0]), .force_y_i(in_q[63:32]),
    .ex_x_i(in_q[95:64]), .ex_y_i(in_q[127:96]), .dt_i(in_q[143:128]),
    .pos_x_i(in_q[175:144]), .pos_y_i(in_q[207:176]),
    .new_pos_x_o(npx), .new_pos_y_o(npy), .vel_x_o(vx), .vel_y_o(vy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (done) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (done) odata_q <= {vy, vx, npy, npx};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;
endmodule
`default_nettype wire

[dv/rigid_body_2d_step_tb.sv]
// self-checking testbench for the 2d rigid body step: directed ticks, then random ticks
`timescale 1ns / 1ps
module rigid_body_2d_step_tb;

  localparam int unsigned RandPerPhase = 272;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned DrainCycles = 300;
  localparam longint CycleLimit = 2000000;

  // packed so that the last field, frc_x, sits in the lowest bits
  typedef struct packed {
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [15:0] dt;
    logic [31:0] eacc_y;
    logic [31:0] eacc_x;
    logic [31:0] frc_y;
    logic [31:0] frc_x;
  } tick_t;

  typedef struct packed {
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] npos_y;
    logic [31:0] npos_x;
  } body_out_t;

  typedef struct {
    tick_t     t;
    bit        typed;
    body_out_t r;
  } drow_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [30:0]       cfg_data_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [207:0]      s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [127:0]      m_axis_tdata;

  // body state and registers as the block should hold them
  longint            mdl_vx, mdl_vy;
  longint unsigned   mdl_mass, mdl_fric, mdl_maxx, mdl_maxy;

  body_out_t         pending_q[$];
  int                errors = 0;
  int                words_seen = 0;
  bit                quiet = 1'b0;
  longint            cycles = 0;

  always #5 clk_i = ~clk_i;

  rigid_body_2d_step dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed_like(longint ref_v, longint unsigned m);
    return ref_v < 0 ? -longint'(m) : longint'(m);
  endfunction

  // magnitude product with the time step, truncated toward zero
  function automatic longint scale_dt(longint v, longint unsigned dt);
    return signed_like(v, (mag(v) * dt) >> 16);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint body_accel(longint frc, longint extra, longint unsigned m);
    longint unsigned q;
    q = (mag(frc) << 16) / m;
    return sat32(signed_like(frc, q) + extra);
  endfunction

  function automatic longint clamp_speed(longint v, longint unsigned lim);
    return mag(v) > lim ? signed_like(v, lim) : v;
  endfunction

  // advances the kept velocity by one tick and returns the expected word
  function automatic body_out_t euler_step(tick_t t);
    longint unsigned dt, m, f, mx, my, sq, s;
    longint ax, ay, vx, vy;
    body_out_t r;
    dt = 64'(t.dt);
    m = mdl_mass != 0 ? mdl_mass : 1;
    ax = body_accel(longint'($signed(t.frc_x)), longint'($signed(t.eacc_x)), m);
    ay = body_accel(longint'($signed(t.frc_y)), longint'($signed(t.eacc_y)), m);
    vx = sat32(mdl_vx + scale_dt(ax, dt));
    vy = sat32(mdl_vy + scale_dt(ay, dt));
    f = (mdl_fric * dt) >> 16;
    mx = mag(vx);
    my = mag(vy);
    sq = mx * mx + my * my;
    if (sq <= f * f) begin
      vx = 0;
      vy = 0;
    end else begin
      s = int_sqrt(sq);
      vx = signed_like(vx, mx - (mx * f) / s);
      vy = signed_like(vy, my - (my * f) / s);
    end
    vx = clamp_speed(vx, mdl_maxx);
    vy = clamp_speed(vy, mdl_maxy);
    mdl_vx = vx;
    mdl_vy = vy;
    r.npos_x = 32'(sat32(longint'($signed(t.pos_x)) + scale_dt(vx, dt)));
    r.npos_y = 32'(sat32(longint'($signed(t.pos_y)) + scale_dt(vy, dt)));
    r.vel_x = 32'(vx);
    r.vel_y = 32'(vy);
    return r;
  endfunction

  function automatic tick_t mk_tick(logic [31:0] fx, logic [31:0] fy, logic [31:0] ex,
                                    logic [31:0] ey, logic [15:0] dt, logic [31:0] px,
                                    logic [31:0] py);
    tick_t t;
    t.frc_x = fx; t.frc_y = fy; t.eacc_x = ex; t.eacc_y = ey;
    t.dt = dt; t.pos_x = px; t.pos_y = py;
    return t;
  endfunction

  function automatic logic [31:0] rand_signed(int unsigned span);
    logic [31:0] v;
    v = $urandom_range(span, 0);
    return $urandom_range(1, 0) ? -v : v;
  endfunction

  // mostly moderate values so the velocity evolves, with some raw noise
  function automatic tick_t rand_tick();
    int unsigned pick;
    tick_t t;
    pick = $urandom_range(99, 0);
    if (pick < 20) begin
      t = {$urandom, $urandom, 16'($urandom), $urandom, $urandom, $urandom, $urandom};
    end else begin
      t.frc_x = rand_signed(32'h0100_0000);
      t.frc_y = rand_signed(32'h0100_0000);
      t.eacc_x = rand_signed(32'h0040_0000);
      t.eacc_y = rand_signed(32'h0040_0000);
      t.dt = pick < 80 ? 16'($urandom_range(4000, 0)) : 16'($urandom_range(65535, 0));
      t.pos_x = pick < 90 ? rand_signed(32'h1000_0000) : $urandom;
      t.pos_y = pick < 90 ? rand_signed(32'h1000_0000) : $urandom;
    end
    return t;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic send_tick(tick_t t, bit typed, body_out_t typed_r);
    body_out_t p;
    if (!quiet) begin
      while ($urandom_range(99, 0) < 14) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= t;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = euler_step(t);
    pending_q.push_back(typed ? typed_r : p);
  endtask

  task automatic write_reg(rb2d_pkg::reg_idx_e idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      rb2d_pkg::RegMass: mdl_mass = 64'(val);
      rb2d_pkg::RegFric: mdl_fric = 64'(val);
      rb2d_pkg::RegMaxX: mdl_maxx = 64'(val);
      default: mdl_maxy = 64'(val);
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // result side: check words, random stalls, one long hold-off
  initial begin
    body_out_t got, want;
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        words_seen++;
        if (pending_q.size() == 0) begin
          report("unexpected word", got.npos_x, '0);
        end else begin
          want = pending_q.pop_front();
          if (got.npos_x !== want.npos_x) report("new_pos_x", got.npos_x, want.npos_x);
          if (got.npos_y !== want.npos_y) report("new_pos_y", got.npos_y, want.npos_y);
          if (got.vel_x !== want.vel_x) report("vel_x", got.vel_x, want.vel_x);
          if (got.vel_y !== want.vel_y) report("vel_y", got.vel_y, want.vel_y);
        end
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!held && words_seen == 150) begin
        held = 1'b1;
        hold = 3000;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99, 0) >= 14);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    drow_t rows[$];
    drow_t d;
    body_out_t z;
    logic [30:0] phase_cfg[NumPhases][4];

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= rb2d_pkg::RegMass;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    mdl_vx = 0;
    mdl_vy = 0;
    mdl_mass = 64'(rb2d_pkg::MassRst);
    mdl_fric = 64'(rb2d_pkg::FricRst);
    mdl_maxx = 64'(rb2d_pkg::MaxXRst);
    mdl_maxy = 64'(rb2d_pkg::MaxYRst);

    // zero mass, no friction, no clamp / heaviest, strongest friction, zero limits
    phase_cfg[0] = '{rb2d_pkg::MassRst, rb2d_pkg::FricRst, rb2d_pkg::MaxXRst,
                     rb2d_pkg::MaxYRst};
    phase_cfg[1] = '{31'd0, 31'd0, 31'h7fff_ffff, 31'h7fff_ffff};
    phase_cfg[2] = '{31'h7fff_ffff, 31'h7fff_ffff, 31'd0, 31'd0};
    phase_cfg[3] = '{31'd98304, 31'd65536, 31'd3276800, 31'd1310720};
    phase_cfg[4] = '{31'd1, 31'd655360, 31'd6553600, 31'd13107200};
    phase_cfg[5] = '{31'($urandom_range(32'h0010_0000, 1)),
                     31'($urandom_range(32'h0100_0000, 0)),
                     31'($urandom), 31'($urandom)};

    // right after reset, ticks with no time step leave the position alone
    // and the body at rest
    z = '0;
    d.typed = 1'b1; d.r = z;
    d.t = '0; rows.push_back(d);
    d.t = mk_tick(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'h0,
                  32'h7fff_ffff, 32'h8000_0000);
    d.r.npos_x = 32'h7fff_ffff; d.r.npos_y = 32'h8000_0000;
    rows.push_back(d);
    d.typed = 1'b0;
    d.t = mk_tick(32'd6553600, 0, 0, 0, 16'hffff, 0, 0); rows.push_back(d);
    d.t = mk_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff,
                  32'h7fff_ff00, 32'h7fff_ff00);
    rows.push_back(d);
    d.t = mk_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff,
                  32'h8000_0000, 32'h8000_0100);
    rows.push_back(d);
    d.t = mk_tick(0, 0, 0, 0, 16'h0400, 0, 0); rows.push_back(d);
    d.t = mk_tick(0, 0, 0, 0, 16'hffff, 32'd100, 32'd100); rows.push_back(d);
    d.t = mk_tick(0, 32'd131072000, 0, 0, 16'h8000, 0, 0); rows.push_back(d);
    d.t = mk_tick(32'hffff_0000, 32'd65536, 32'hfff0_0000, 32'd1048576, 16'h0001,
                  32'hffff_ffff, 32'd1);
    rows.push_back(d);
    d.t = mk_tick(32'd65536, 32'hffff_ffff, 0, 32'h7fff_ffff, 16'h8000, 0, 0);
    rows.push_back(d);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_tick(rows[i].t, rows[i].typed, rows[i].r);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        drain();
        write_reg(rb2d_pkg::RegMass, phase_cfg[ph][0]);
        write_reg(rb2d_pkg::RegFric, phase_cfg[ph][1]);
        write_reg(rb2d_pkg::RegMaxX, phase_cfg[ph][2]);
        write_reg(rb2d_pkg::RegMaxY, phase_cfg[ph][3]);
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end
      quiet = (ph == 3);
      for (int n = 0; n < RandPerPhase; n++) send_tick(rand_tick(), 1'b0, z);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
